[hw/rtl/log_exp_format_convert_top_assert.svh]
// assertion macros for the log/exp format converter
// used by log_exp_format_convert_top; no other dependencies
`ifndef LOG_EXP_FORMAT_CONVERT_TOP_ASSERT_SVH
`define LOG_EXP_FORMAT_CONVERT_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define LEFC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lefc assertion failed");
`define LEFC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lefc assertion failed");
`else
`define LEFC_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define LEFC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[hw/rtl/lefc_pkg.sv]
// types, codes and helpers for the log/exp format converter
// no dependencies
package lefc_pkg;

  localparam logic KIND_LOG = 1'b0;
  localparam logic KIND_LIN = 1'b1;

  localparam logic [1:0] SGN_FOLLOW  = 2'd0;
  localparam logic [1:0] SGN_NEVER   = 2'd1;
  localparam logic [1:0] SGN_ALWAYS  = 2'd2;
  localparam logic [1:0] SGN_INVERSE = 2'd3;

  localparam logic [4:0] MAX_EXP_MIN = 5'd2;
  localparam logic [4:0] POS_EXP5    = 5'd26;
  localparam logic [4:0] POS_EXP4    = 5'd27;
  localparam logic [4:0] POS_EXP3    = 5'd28;
  localparam logic [4:0] POS_EXP2    = 5'd29;

  typedef struct packed {
    logic        kind;
    logic        neg;
    logic [1:0]  mode;
    logic [31:0] mag;
    logic [4:0]  max_exp;
    logic [4:0]  pos;
    logic [5:0]  lz;
  } s1_t;

  typedef struct packed {
    logic        kind;
    logic        neg;
    logic [1:0]  mode;
    logic [31:0] mant;
    logic [5:0]  expo;
    logic [4:0]  pos;
  } s2_t;

  function automatic logic [5:0] lzc32(input logic [31:0] v);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 6'(31 - i);
    end
    return n;
  endfunction

endpackage

[hw/rtl/log_exp_format_convert_top.sv]
// log/exp word format converter, three-stage pipeline
// depends on lefc_pkg and log_exp_format_convert_top_assert.svh
//
// usage:
//   in_*  channel carries one conversion per transfer; in_tuser selects the
//         operation (0 linear-to-log, 1 log-to-linear), in_tdata holds the
//         word, the maximum exponent and the sign control
//   out_* channel returns one converted 32-bit word per input transfer,
//         in input order
// each transfer passes the stage 1, stage 2 and result registers before out_tvalid
// throughput: one item per cycle while out_tready is high; stage 1 complements,
//   clamps and counts leading zeros, stage 2 runs the normalize/unpack shifter,
//   stage 3 packs or denormalizes and applies the sign control
// reset: rst_n low empties the pipeline; no other state is kept
// stall: with out_tready low the output holds its word, earlier stages
//   keep filling bubbles, and in_tready drops once all three stages are full
module log_exp_format_convert_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // data_word[31:0], max_exponent[36:32], sign_mode[38:37]
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // result_word[31:0]
);

  `include "log_exp_format_convert_top_assert.svh"

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  lefc_pkg::s1_t s1_r, s1_nxt;
  lefc_pkg::s2_t s2_r, s2_nxt;
  logic [31:0] res_r, res_nxt;

  assign rdy3 = !v3_r || out_tready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign out_tvalid = v3_r;
  assign out_tdata = res_r;

  // stage 1: complement, clamp, field position, leading zeros
  always_comb begin
    logic [31:0] w;
    logic [4:0]  mx;
    w  = in_tdata[31:0];
    mx = in_tdata[36:32];
    s1_nxt.kind    = in_tuser;
    s1_nxt.neg     = w[31];
    s1_nxt.mode    = in_tdata[38:37];
    s1_nxt.mag     = w[31] ? ~w : w;
    s1_nxt.max_exp = (mx < lefc_pkg::MAX_EXP_MIN) ? lefc_pkg::MAX_EXP_MIN : mx;
    if (s1_nxt.max_exp[4]) begin
      s1_nxt.pos = lefc_pkg::POS_EXP5;
    end else if (s1_nxt.max_exp[3]) begin
      s1_nxt.pos = lefc_pkg::POS_EXP4;
    end else if (s1_nxt.max_exp[2]) begin
      s1_nxt.pos = lefc_pkg::POS_EXP3;
    end else begin
      s1_nxt.pos = lefc_pkg::POS_EXP2;
    end
    s1_nxt.lz = lefc_pkg::lzc32(s1_nxt.mag);
  end

  // stage 2: normalize (log) or unpack and find shift (linear)
  always_comb begin
    logic [5:0]  e0;
    logic [5:0]  sl;
    logic [5:0]  el;
    logic [31:0] ml;
    logic [4:0]  ex;
    logic [31:0] mn;
    logic [4:0]  sh;
    e0 = {1'b0, s1_r.max_exp} + 6'd1;
    sl = (s1_r.lz < e0) ? s1_r.lz : e0;
    el = e0 - sl;
    ml = s1_r.mag << sl;
    if (el != 6'd0) ml = ml << 1;
    ex = 5'(s1_r.mag >> s1_r.pos);
    mn = s1_r.mag << (6'd32 - {1'b0, s1_r.pos});
    if (ex != 5'd0) begin
      mn = {1'b1, mn[31:1]};
      ex = ex - 5'd1;
    end
    sh = (ex > s1_r.max_exp) ? 5'd0 : (s1_r.max_exp - ex);
    s2_nxt.kind = s1_r.kind;
    s2_nxt.neg  = s1_r.neg;
    s2_nxt.mode = s1_r.mode;
    s2_nxt.pos  = s1_r.pos;
    if (s1_r.kind == lefc_pkg::KIND_LIN) begin
      s2_nxt.mant = mn;
      s2_nxt.expo = {1'b0, sh};
    end else begin
      s2_nxt.mant = ml;
      s2_nxt.expo = el;
    end
  end

  // stage 3: pack or denormalize, then sign control
  always_comb begin
    logic [31:0] r;
    logic        cpl;
    if (s2_r.kind == lefc_pkg::KIND_LIN) begin
      r = s2_r.mant >> s2_r.expo[4:0];
    end else begin
      r = (32'(s2_r.expo) << s2_r.pos) | (s2_r.mant >> (6'd32 - {1'b0, s2_r.pos}));
    end
    case (s2_r.mode)
      lefc_pkg::SGN_FOLLOW:  cpl = s2_r.neg;
      lefc_pkg::SGN_NEVER:   cpl = 1'b0;
      lefc_pkg::SGN_ALWAYS:  cpl = 1'b1;
      lefc_pkg::SGN_INVERSE: cpl = !s2_r.neg;
      default:               cpl = 1'b0;
    endcase
    res_nxt = cpl ? ~r : r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) s1_r <= s1_nxt;
    if (rdy2 && v1_r) s2_r <= s2_nxt;
    if (rdy3 && v2_r) res_r <= res_nxt;
  end

  `LEFC_ASSERT_SAME(a_full_when_blocked, clk, rst_n, !in_tready, v1_r && v2_r && v3_r)
  `LEFC_ASSERT_NEXT(a_s1_advances, clk, rst_n, v1_r && rdy2, v2_r)
  `LEFC_ASSERT_NEXT(a_s2_advances, clk, rst_n, v2_r && rdy3, out_tvalid)

endmodule

[tb/sv/log_exp_format_convert_top_tb.sv]
// self-checking testbench for log_exp_format_convert_top: directed and random conversions,
// each result checked in order against a predictor of the log/linear word conversion
// depends on lefc_pkg and the log_exp_format_convert_top rtl
module log_exp_format_convert_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 275;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  logic [31:0] expected_words[$];
  int          error_count = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  log_exp_format_convert_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] apply_sign_mode(logic [31:0] r, logic neg, logic [1:0] mode);
    case (mode)
      lefc_pkg::SGN_FOLLOW: begin
        return neg ? ~r : r;
      end
      lefc_pkg::SGN_ALWAYS: begin
        return ~r;
      end
      lefc_pkg::SGN_INVERSE: begin
        return neg ? r : ~r;
      end
      default: begin
        return r;
      end
    endcase
  endfunction

  function automatic logic [31:0] convert_word(logic kind, logic [31:0] word,
                                               logic [4:0] max_exp_in, logic [1:0] mode);
    logic        neg;
    logic [31:0] mag;
    logic [4:0]  max_exp;
    int          pos;
    logic [5:0]  expo;
    neg = word[31];
    mag = neg ? ~word : word;
    max_exp = (max_exp_in < lefc_pkg::MAX_EXP_MIN) ? lefc_pkg::MAX_EXP_MIN : max_exp_in;
    if (max_exp[4]) begin
      pos = int'(lefc_pkg::POS_EXP5);
    end else if (max_exp[3]) begin
      pos = int'(lefc_pkg::POS_EXP4);
    end else if (max_exp[2]) begin
      pos = int'(lefc_pkg::POS_EXP3);
    end else begin
      pos = int'(lefc_pkg::POS_EXP2);
    end
    if (kind == lefc_pkg::KIND_LOG) begin
      expo = 6'(max_exp) + 6'd1;
      while (!mag[31] && expo != 6'd0) begin
        mag = mag << 1;
        expo = expo - 6'd1;
      end
      if (expo != 6'd0) mag = mag << 1;
      mag = (32'(expo) << pos) | (mag >> (32 - pos));
    end else begin
      expo = 6'(mag >> pos);
      mag = mag << (32 - pos);
      if (expo != 6'd0) begin
        mag = (mag >> 1) | 32'h8000_0000;
        expo = expo - 6'd1;
      end
      if (expo <= 6'(max_exp)) mag = mag >> (6'(max_exp) - expo);
    end
    return apply_sign_mode(mag, neg, mode);
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(logic kind, logic [31:0] word, logic [4:0] max_exp, logic [1:0] mode);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, mode, max_exp, word};
    do @(posedge clk); while (!in_tready);
    expected_words.push_back(convert_word(kind, word, max_exp, mode));
  endtask

  task automatic send_random_items(int count);
    logic        kind;
    logic [31:0] word;
    for (int i = 0; i < count; i++) begin
      kind = 1'($urandom_range(1));
      word = $urandom;
      if ($urandom_range(1)) word = word >> $urandom_range(31);
      if ($urandom_range(1)) word = ~word;
      send_item(kind, word, 5'($urandom_range(31)), 2'($urandom_range(3)));
    end
  endtask

  task automatic test_small_max;
    send_item(lefc_pkg::KIND_LOG, 32'h0001_2345, 5'd0, lefc_pkg::SGN_FOLLOW);
    send_item(lefc_pkg::KIND_LOG, 32'hFFFE_DCBA, 5'd1, lefc_pkg::SGN_FOLLOW);
    send_item(lefc_pkg::KIND_LIN, 32'h5A5A_5A5A, 5'd0, lefc_pkg::SGN_FOLLOW);
    send_item(lefc_pkg::KIND_LIN, 32'hA5A5_A5A5, 5'd1, lefc_pkg::SGN_FOLLOW);
  endtask

  task automatic test_full_exponent;
    send_item(lefc_pkg::KIND_LOG, 32'h4000_0000, 5'd31, lefc_pkg::SGN_FOLLOW);
    send_item(lefc_pkg::KIND_LOG, 32'hBFFF_FFFF, 5'd15, lefc_pkg::SGN_FOLLOW);
    send_item(lefc_pkg::KIND_LOG, 32'h4000_0001, 5'd7, lefc_pkg::SGN_FOLLOW);
    send_item(lefc_pkg::KIND_LOG, 32'h7FFF_FFFF, 5'd3, lefc_pkg::SGN_FOLLOW);
  endtask

  task automatic test_zero_magnitude;
    send_item(lefc_pkg::KIND_LOG, 32'h0000_0000, 5'd31, lefc_pkg::SGN_FOLLOW);
    send_item(lefc_pkg::KIND_LOG, 32'hFFFF_FFFF, 5'd2, lefc_pkg::SGN_FOLLOW);
    send_item(lefc_pkg::KIND_LOG, 32'h8000_0000, 5'd16, lefc_pkg::SGN_FOLLOW);
    send_item(lefc_pkg::KIND_LIN, 32'h0000_0000, 5'd31, lefc_pkg::SGN_FOLLOW);
  endtask

  // decremented stored exponent above the maximum: no shift
  task automatic test_large_stored_exponent;
    send_item(lefc_pkg::KIND_LIN, 32'h7FFF_FFFF, 5'd16, lefc_pkg::SGN_FOLLOW);
    send_item(lefc_pkg::KIND_LIN, 32'h8000_0000, 5'd16, lefc_pkg::SGN_FOLLOW);
    send_item(lefc_pkg::KIND_LIN, 32'h7123_4567, 5'd4, lefc_pkg::SGN_FOLLOW);
    send_item(lefc_pkg::KIND_LIN, 32'h6ABC_DEF0, 5'd8, lefc_pkg::SGN_FOLLOW);
  endtask

  task automatic test_sign_modes;
    logic [1:0] modes[4];
    modes = '{lefc_pkg::SGN_FOLLOW, lefc_pkg::SGN_NEVER,
              lefc_pkg::SGN_ALWAYS, lefc_pkg::SGN_INVERSE};
    foreach (modes[i]) begin
      send_item(lefc_pkg::KIND_LOG, 32'h0034_5678, 5'd12, modes[i]);
      send_item(lefc_pkg::KIND_LIN, 32'hC123_4567, 5'd20, modes[i]);
    end
  endtask

  task automatic test_random_no_idle;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random_items(PHASE_ITEMS);
  endtask

  task automatic test_random_sender_idle;
    send_idle_pct = 81;
    recv_stall_pct = 0;
    send_random_items(PHASE_ITEMS);
  endtask

  task automatic test_random_receiver_stall;
    send_idle_pct = 0;
    recv_stall_pct = 81;
    send_random_items(PHASE_ITEMS);
  endtask

  task automatic test_random_both_idle;
    send_idle_pct = 33;
    recv_stall_pct = 33;
    send_random_items(PHASE_ITEMS);
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker, in order
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        $error("result_word unexpected transfer, actual %h", out_tdata);
        error_count++;
      end else begin
        if (out_tdata !== expected_words[0]) begin
          $error("result_word expected %h actual %h", expected_words[0], out_tdata);
          error_count++;
        end
        void'(expected_words.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_small_max();
    test_full_exponent();
    test_zero_magnitude();
    test_large_stored_exponent();
    test_sign_modes();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
